/* rtl/dlpg_pkg.sv */
// dlpg_pkg: shared types and constants of the dotted line point generator.
// Depends on nothing; used by every module in rtl/.
package dlpg_pkg;

  localparam int unsigned MaxDots  = 64;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned SizeW    = 12;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned DiffW    = 17;  // end minus start
  localparam int unsigned SqW      = 35;  // dx*dx + dy*dy
  localparam int unsigned LenW     = 18;  // isqrt of SqW bits
  localparam int unsigned StepW    = 13;  // size + gap
  localparam int unsigned DivW     = 37;  // dividend width of the shared divider
  localparam int unsigned CntW     = $clog2(MaxDots);
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CNT,
    ST_DIVX,
    ST_DIVY,
    ST_EMIT,
    ST_END
  } state_e;

  // handshake between sequencer and the shared divider
  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  num;
    logic [LenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivW-1:0]  quo;
  } div_rsp_t;

endpackage

/* rtl/dlpg_isqrt.sv */
// dlpg_isqrt: bit-pair iterative floor square root, two result bits per
// cycle pair. Depends on dlpg_pkg.
module dlpg_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [dlpg_pkg::SqW-1:0] rad_i,
  output logic                     done_o,
  output logic [dlpg_pkg::LenW-1:0] root_o
);
  import dlpg_pkg::*;

  localparam int unsigned Steps = LenW;
  localparam int unsigned RemW  = LenW + 2;

  logic [2*LenW-1:0]        rad_q, rad_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [LenW-1:0]          root_q, root_d;
  logic [$clog2(Steps+1)-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic [RemW-1:0]          trial;
  logic [RemW-1:0]          rem_sh;

  // one result bit per cycle
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[RemW-3:0], rad_q[2*LenW-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = {{(2*LenW-SqW){1'b0}}, rad_i};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[2*LenW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[LenW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[LenW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(Steps+1))'(Steps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && !busy_d;
  assign root_o = root_d;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("isqrt restarted while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("isqrt done held");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < ($clog2(Steps+1))'(Steps)) else $error("isqrt count overrun");
`endif
endmodule

/* rtl/dlpg_div.sv */
// dlpg_div: restoring divider, one quotient bit per cycle.
// Depends on dlpg_pkg.
module dlpg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlpg_pkg::div_req_t req_i,
  output dlpg_pkg::div_rsp_t rsp_o
);
  import dlpg_pkg::*;

  localparam int unsigned RemW = LenW + 1;

  logic [DivW-1:0]          quo_q, quo_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [LenW-1:0]          den_q, den_d;
  logic [$clog2(DivW+1)-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [RemW:0]            rem_sh;

  // shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, quo_q[DivW-1]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {2'b00, den_q}) begin
        rem_d = RemW'(rem_sh - {2'b00, den_q});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = RemW'(rem_sh);
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(DivW+1))'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // done is registered: it rises in the cycle after the last step, quotient held in quo_q
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.den != '0) else $error("divide by zero");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done) else $error("divider done held");
`endif
endmodule

/* rtl/dotted_line_point_generator.sv */
// Channel | dir | payload
// s_axis  | in  | tdata: start_x, start_y, end_x, end_y, quad_size, gap, color_rgb
// m_axis  | out | tdata: dot_x, dot_y, dot_size, dot_color; tuser: truncated; tlast
// Steps: square root, dot count division, first dot; each further line dot
//   takes two divisions (x, then y) plus one output, then come the end dot
//   and the return to idle.
// The divider and square root run one bit per cycle; one item at a time.
// Reset clears the sequencer and the output valid; a stalled output holds
//   the sequencer until the transaction completes.
// Top level: sequencer around a shared isqrt and divider. Depends on
//   dlpg_pkg, dlpg_isqrt, dlpg_div.
module dotted_line_point_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, end_x, end_y, quad_size, gap, color_rgb
  input  logic [dlpg_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dot_x, dot_y, dot_size, dot_color
  output logic [dlpg_pkg::OutDataW-1:0]  m_axis_tdata,
  // truncated
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import dlpg_pkg::*;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [SizeW-1:0]         size_q;
  logic [StepW-1:0]         step_q;
  logic [ColorW-1:0]        color_q;
  logic signed [DiffW-1:0]  dx_q, dy_q;
  logic [LenW-1:0]          len_q;
  logic                     trunc_q, trunc_d;
  logic [CntW-1:0]          nline_q, nline_d;   // line dots minus one
  logic [CntW-1:0]          k_q, k_d;
  logic [LenW+CntW-1:0]     dist_q, dist_d;     // k*step, accumulated
  logic signed [CoordW-1:0] px_q, px_d;
  logic signed [CoordW-1:0] py_q, py_d;

  logic signed [DiffW-1:0]  dx_w, dy_w;
  logic [SqW-1:0]           sq_w;
  logic                     sq_start, sq_done;
  logic [LenW-1:0]          root_w;
  div_req_t                 dreq;
  div_rsp_t                 drsp;
  logic [DiffW-2:0]         mag_w;
  logic                     neg_w;
  logic [DivW-1:0]          prod_w;
  logic [DivW-1:0]          q_w;
  logic signed [CoordW-1:0] off_w;
  logic                     out_fire, in_fire;
  logic                     mv_q, mv_d;
  logic [OutDataW-1:0]      md_q, md_d;
  logic                     ml_q, ml_d, mu_q, mu_d;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign dx_w = DiffW'($signed(s_axis_tdata[47:32])) - DiffW'($signed(s_axis_tdata[15:0]));
  assign dy_w = DiffW'($signed(s_axis_tdata[63:48])) - DiffW'($signed(s_axis_tdata[31:16]));
  assign sq_w = SqW'(34'(dx_w * dx_w)) + SqW'(34'(dy_w * dy_w));
  assign sq_start = in_fire;

  dlpg_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_w),
    .done_o(sq_done), .root_o(root_w)
  );

  // operand for the shared divider: count pass or a coordinate pass
  always_comb begin
    // sign of the axis whose quotient is returning
    neg_w = (state_q == ST_DIVY) ? dy_q[DiffW-1] : dx_q[DiffW-1];
    // magnitude of the axis being started
    mag_w = (state_d == ST_DIVY) ? (DiffW-1)'(dy_q[DiffW-1] ? -dy_q : dy_q)
                                 : (DiffW-1)'(dx_q[DiffW-1] ? -dx_q : dx_q);
    // 2*dist*|d| + len, divided by len; the quotient is halved below
    prod_w = DivW'({dist_d, 1'b0} * mag_w) + DivW'(len_q);
    dreq.start = 1'b0;
    dreq.num   = prod_w;
    dreq.den   = len_q;
    if (state_q == ST_SQRT && sq_done) begin
      dreq.start = (root_w != '0) && (step_q != '0);
      dreq.num   = DivW'(root_w);
      dreq.den   = LenW'(step_q);
    end else if ((state_q != state_d) && (state_d == ST_DIVX || state_d == ST_DIVY)) begin
      dreq.start = 1'b1;
    end
  end

  dlpg_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // quotient of (2m+len)/len halved gives round(m/len)
  assign q_w   = drsp.quo >> 1;
  assign off_w = neg_w ? -CoordW'(q_w) : CoordW'(q_w);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SQRT;
      ST_SQRT: if (sq_done) state_d = dreq.start ? ST_CNT : ST_EMIT;
      ST_CNT:  if (drsp.done) state_d = ST_EMIT;
      ST_DIVX: if (drsp.done) state_d = ST_DIVY;
      ST_DIVY: if (drsp.done) state_d = ST_EMIT;
      ST_EMIT: if (!mv_q || out_fire)
                 state_d = (k_q == nline_q) ? ST_END : ST_DIVX;
      ST_END:  if (!mv_q || out_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    trunc_d = trunc_q;
    nline_d = nline_q;
    k_d     = k_q;
    dist_d  = dist_q;
    px_d    = px_q;
    py_d    = py_q;
    mv_d    = mv_q && !out_fire;
    md_d    = md_q;
    ml_d    = ml_q;
    mu_d    = mu_q;
    unique case (state_q)
      ST_IDLE: begin
        trunc_d = 1'b0;
        nline_d = '0;
        k_d     = '0;
        dist_d  = '0;
      end
      ST_SQRT: ;
      ST_CNT: if (drsp.done) begin
        if (drsp.quo >= DivW'(MaxDots - 1)) begin
          nline_d = CntW'(MaxDots - 2);
          trunc_d = (drsp.quo != DivW'(MaxDots - 2));
        end else begin
          nline_d = CntW'(drsp.quo);
        end
      end
      ST_DIVX: if (drsp.done) px_d = sx_q + off_w;
      ST_DIVY: if (drsp.done) py_d = sy_q + off_w;
      ST_EMIT: if (!mv_q || out_fire) begin
        mv_d = 1'b1;
        ml_d = 1'b0;
        mu_d = trunc_q;
        if (k_q == '0) md_d = OutDataW'({color_q, size_q, sy_q, sx_q});
        else           md_d = OutDataW'({color_q, size_q, py_q, px_q});
        k_d    = k_q + 1'b1;
        dist_d = dist_q + (LenW+CntW)'(step_q);
      end
      ST_END: if (!mv_q || out_fire) begin
        mv_d = 1'b1;
        ml_d = 1'b1;
        mu_d = trunc_q;
        md_d = OutDataW'({color_q, size_q, ey_q, ex_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sx_q    <= s_axis_tdata[15:0];
      sy_q    <= s_axis_tdata[31:16];
      ex_q    <= s_axis_tdata[47:32];
      ey_q    <= s_axis_tdata[63:48];
      size_q  <= s_axis_tdata[75:64];
      step_q  <= StepW'(s_axis_tdata[75:64]) + StepW'(s_axis_tdata[87:76]);
      color_q <= s_axis_tdata[111:88];
      dx_q    <= dx_w;
      dy_q    <= dy_w;
    end
    if (sq_done) len_q <= root_w;
    trunc_q <= trunc_d;
    nline_q <= nline_d;
    k_q     <= k_d;
    dist_q  <= dist_d;
    px_q    <= px_d;
    py_q    <= py_d;
    md_q    <= md_d;
    ml_q    <= ml_d;
    mu_q    <= mu_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tlast  = ml_q;
  assign m_axis_tuser  = mu_q;

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END && state_d == ST_IDLE) |=> m_axis_tlast && m_axis_tvalid)
    else $error("end dot not flagged last");
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> k_q <= nline_q) else $error("dot count overrun");
`endif
endmodule
